>>> sv/fru_pkg.sv
// fru info area parser: shared types, codes and constants
// used by the front, queue, back and top level modules
`timescale 1ns / 1ps
`default_nettype none

package fru_pkg;

    // parse phase of the front state machine
    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_TL   = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // role of one byte in the result
    typedef enum logic [2:0] {
        ROLE_HEADER   = 3'd0,
        ROLE_TYPELEN  = 3'd1,
        ROLE_DATA     = 3'd2,
        ROLE_SENTINEL = 3'd3,
        ROLE_IGNORED  = 3'd4,
        ROLE_ERROR    = 3'd5
    } t_role;

    // area status
    typedef enum logic [1:0] {
        ST_PARSING      = 2'd0,
        ST_OK           = 2'd1,
        ST_INCONSISTENT = 2'd2,
        ST_OVERFLOW     = 2'd3
    } t_status;

    // area kind register codes
    localparam logic [1:0] KIND_CHASSIS = 2'd0;
    localparam logic [1:0] KIND_BOARD   = 2'd1;
    localparam logic [1:0] KIND_PRODUCT = 2'd2;

    // configuration register indexes
    localparam logic CFG_AREA_KIND    = 1'b0;
    localparam logic CFG_CUSTOM_LIMIT = 1'b1;

    // fixed field counts per area kind
    localparam logic [2:0] FIXED_CHASSIS = 3'd2;
    localparam logic [2:0] FIXED_BOARD   = 3'd5;
    localparam logic [2:0] FIXED_PRODUCT = 3'd7;

    // type/length decode
    localparam logic [1:0] SENTINEL_TYPE   = 2'd3;
    localparam logic [5:0] SENTINEL_LENGTH = 6'h01;
    localparam logic [7:0] SENTINEL_BYTE   = {SENTINEL_TYPE, SENTINEL_LENGTH};

    // manufacturing time: minutes since 1996-01-01 to seconds, shifted by 26 years of 365 days
    localparam logic [30:0] EPOCH_SHIFT_SECONDS = 31'(26 * 365 * 24 * 60 * 60);

    // one classified byte, front to back
    typedef struct packed {
        t_role       role;
        logic [7:0]  field_number;
        logic [1:0]  field_type;
        logic [5:0]  field_length;
        logic [7:0]  data_byte;
        logic [7:0]  header_value;
        t_status     status;
        logic        area_done;
        logic        mfg_valid;
        logic        date_load;
        logic [23:0] date_minutes;
    } t_rec;

endpackage

`default_nettype wire

>>> sv/fru_front.sv
// fru front: configuration registers and the per-byte parse state machine
// depends on fru_pkg; emits one classified record per accepted byte
`timescale 1ns / 1ps
`default_nettype none

module fru_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic          i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_area_byte,
    input  wire logic          i_last_byte,
    output fru_pkg::t_rec      o_rec
);
    import fru_pkg::*;

    // configuration
    logic [1:0] r_area_kind;
    logic [7:0] r_custom_limit;

    // parse state
    t_phase     r_phase,        n_phase;
    logic [1:0] r_header_count, n_header_count;
    logic [15:0] r_date_lo,     n_date_lo;
    logic       r_date_valid,   n_date_valid;
    logic [5:0] r_data_left,    n_data_left;
    logic [7:0] r_field_count,  n_field_count;
    logic [7:0] r_custom_count, n_custom_count;
    logic [1:0] r_cur_type,     n_cur_type;
    logic [5:0] r_cur_length,   n_cur_length;
    t_status    r_final_status, n_final_status;

    // decode signals
    logic       w_board;
    logic [7:0] w_fixed;
    logic       w_head_end;
    logic       w_date_load;
    logic [1:0] w_tc;
    logic [5:0] w_fl;
    logic       w_custom;
    logic       w_tl_sentinel;
    logic       w_tl_over;
    logic       w_tl_bad;
    logic       w_tl_past;
    logic       w_tl_ok;
    logic [5:0] w_dl_next;
    logic [7:0] w_fc_inc;
    logic [7:0] w_fc_data;
    t_status    w_status;
    logic       w_ends;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_kind    <= KIND_CHASSIS;
            r_custom_limit <= 8'd0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_AREA_KIND) begin
                r_area_kind <= i_cfg_data[1:0];
            end else begin
                r_custom_limit <= i_cfg_data;
            end
        end
    end

    // byte classification and area status
    always_comb begin
        w_board = (r_area_kind == KIND_BOARD);
        unique case (r_area_kind)
            KIND_CHASSIS: w_fixed = {5'd0, FIXED_CHASSIS};
            KIND_BOARD:   w_fixed = {5'd0, FIXED_BOARD};
            default:      w_fixed = {5'd0, FIXED_PRODUCT};
        endcase
        w_head_end  = w_board ? (r_header_count == 2'd3) : 1'b1;
        w_date_load = (r_phase == PH_HEAD) && w_board && (r_header_count == 2'd3);

        w_tc          = i_area_byte[7:6];
        w_fl          = i_area_byte[5:0];
        w_custom      = (r_field_count >= w_fixed);
        w_tl_sentinel = w_custom && (i_area_byte == SENTINEL_BYTE);
        w_tl_over     = w_custom && (r_custom_limit != 8'd0)
                        && (r_custom_count >= r_custom_limit);
        w_tl_bad      = (w_tc == SENTINEL_TYPE) && (w_fl == SENTINEL_LENGTH);
        w_tl_past     = i_last_byte && (w_fl != 6'd0);
        w_tl_ok       = !w_tl_sentinel && !w_tl_over && !w_tl_bad && !w_tl_past;

        w_dl_next = (r_data_left != 6'd0) ? r_data_left - 6'd1 : r_data_left;
        w_fc_inc  = (r_field_count != 8'hFF) ? r_field_count + 8'd1 : r_field_count;
        w_fc_data = (w_dl_next == 6'd0) ? w_fc_inc : r_field_count;

        unique case (r_phase)
            PH_HEAD: begin
                w_status = i_last_byte ? ST_INCONSISTENT : ST_PARSING;
            end
            PH_TL: begin
                if (w_tl_sentinel) begin
                    w_status = ST_OK;
                end else if (w_tl_over) begin
                    w_status = ST_OVERFLOW;
                end else if (w_tl_bad || w_tl_past) begin
                    w_status = ST_INCONSISTENT;
                end else if (i_last_byte) begin
                    // an empty field closes here, so it counts toward the fixed fields
                    w_status = (w_fc_inc < w_fixed) ? ST_INCONSISTENT : ST_OK;
                end else begin
                    w_status = ST_PARSING;
                end
            end
            PH_DATA: begin
                if (!i_last_byte) begin
                    w_status = ST_PARSING;
                end else if ((w_dl_next != 6'd0) || (w_fc_data < w_fixed)) begin
                    w_status = ST_INCONSISTENT;
                end else begin
                    w_status = ST_OK;
                end
            end
            default: begin
                w_status = r_final_status;
            end
        endcase
        w_ends = (r_phase != PH_DONE) && (w_status != ST_PARSING);
    end

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_date_lo      = r_date_lo;
        n_date_valid   = r_date_valid;
        n_data_left    = r_data_left;
        n_field_count  = r_field_count;
        n_custom_count = r_custom_count;
        n_cur_type     = r_cur_type;
        n_cur_length   = r_cur_length;
        n_final_status = r_final_status;

        unique case (r_phase)
            PH_HEAD: begin
                if (r_header_count == 2'd0) begin
                    n_date_valid = 1'b0;
                end else if (w_board && r_header_count == 2'd1) begin
                    n_date_lo[7:0] = i_area_byte;
                end else if (w_board && r_header_count == 2'd2) begin
                    n_date_lo[15:8] = i_area_byte;
                end
                if (w_head_end) begin
                    if (w_date_load) begin
                        n_date_valid = 1'b1;
                    end
                    n_phase = PH_TL;
                end else begin
                    n_header_count = r_header_count + 2'd1;
                end
            end
            PH_TL: begin
                if (w_tl_ok) begin
                    n_cur_type   = w_tc;
                    n_cur_length = w_fl;
                    if (w_custom && r_custom_count != 8'hFF) begin
                        n_custom_count = r_custom_count + 8'd1;
                    end
                    if (w_fl == 6'd0) begin
                        n_field_count = w_fc_inc;
                    end else begin
                        n_phase     = PH_DATA;
                        n_data_left = w_fl;
                    end
                end
            end
            PH_DATA: begin
                n_data_left   = w_dl_next;
                n_field_count = w_fc_data;
                if (w_dl_next == 6'd0) begin
                    n_phase = PH_TL;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // area finished early or at its end
        if (w_ends) begin
            n_phase        = PH_DONE;
            n_final_status = w_status;
        end

        // last byte returns the phase, counts and field state to the start of an area
        if (i_last_byte) begin
            n_phase        = PH_HEAD;
            n_header_count = 2'd0;
            n_date_valid   = 1'b0;
            n_data_left    = 6'd0;
            n_field_count  = 8'd0;
            n_custom_count = 8'd0;
            n_cur_type     = 2'd0;
            n_cur_length   = 6'd0;
            n_final_status = ST_PARSING;
        end
    end

    // record fields
    always_comb begin
        o_rec              = '0;
        o_rec.data_byte    = i_area_byte;
        o_rec.status       = w_status;
        o_rec.area_done    = i_last_byte;
        o_rec.date_load    = w_date_load;
        o_rec.date_minutes = {i_area_byte, r_date_lo};
        o_rec.mfg_valid    = r_date_valid || w_date_load;

        unique case (r_phase)
            PH_HEAD: begin
                o_rec.role = ROLE_HEADER;
                if (r_header_count == 2'd0) begin
                    o_rec.header_value = i_area_byte;
                end
            end
            PH_TL: begin
                o_rec.field_number = r_field_count;
                o_rec.field_type   = w_tc;
                o_rec.field_length = w_fl;
                if (w_tl_sentinel) begin
                    o_rec.role = ROLE_SENTINEL;
                end else if (w_tl_ok) begin
                    o_rec.role = ROLE_TYPELEN;
                end else begin
                    o_rec.role = ROLE_HEADER;
                end
            end
            PH_DATA: begin
                o_rec.role         = ROLE_DATA;
                o_rec.field_number = r_field_count;
                o_rec.field_type   = r_cur_type;
                o_rec.field_length = r_cur_length;
            end
            default: begin
                o_rec.role = ROLE_IGNORED;
            end
        endcase

        if (w_ends && (w_status inside {ST_INCONSISTENT, ST_OVERFLOW})) begin
            o_rec.role = ROLE_ERROR;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEAD;
            r_header_count <= 2'd0;
            r_date_valid   <= 1'b0;
            r_data_left    <= 6'd0;
            r_field_count  <= 8'd0;
            r_custom_count <= 8'd0;
            r_cur_type     <= 2'd0;
            r_cur_length   <= 6'd0;
            r_final_status <= ST_PARSING;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_date_valid   <= n_date_valid;
            r_data_left    <= n_data_left;
            r_field_count  <= n_field_count;
            r_custom_count <= n_custom_count;
            r_cur_type     <= n_cur_type;
            r_cur_length   <= n_cur_length;
            r_final_status <= n_final_status;
        end
    end

    // date bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_date_lo <= n_date_lo;
        end
    end

    // a finished area always carries a final status
    a_done_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_final_status != ST_PARSING))
        else $error("front: done phase without final status");

    // data phase always owes at least one byte
    a_data_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_data_left != 6'd0))
        else $error("front: data phase with no bytes left");

    // custom fields are a subset of all fields
    a_custom_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_custom_count <= r_field_count)
        else $error("front: custom count above field count");

endmodule

`default_nettype wire

>>> sv/fru_queue.sv
// fru queue: small fifo of classified records between front and back
// depends on fru_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module fru_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fru_pkg::t_rec i_rec,
    input  wire logic          i_pop,
    output fru_pkg::t_rec      o_rec,
    output logic               o_full,
    output logic               o_not_empty
);
    import fru_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_rec       = r_mem[r_rd_ptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // fill count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue: count above depth");

    // a pop only takes a stored record
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue: pop while empty");

endmodule

`default_nettype wire

>>> sv/fru_back.sv
// fru back: manufacturing time conversion and the result output register
// depends on fru_pkg for the record type and epoch constant
`timescale 1ns / 1ps
`default_nettype none

module fru_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rec_valid,
    input  wire fru_pkg::t_rec i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_byte_role,
    output logic [7:0]         o_field_number,
    output logic [1:0]         o_field_type,
    output logic [5:0]         o_field_length,
    output logic [7:0]         o_data_byte,
    output logic [7:0]         o_header_value,
    output logic [30:0]        o_mfg_seconds,
    output logic [1:0]         o_status,
    output logic               o_area_done
);
    import fru_pkg::*;

    logic        r_valid;
    t_rec        r_out;
    logic [30:0] r_out_seconds;
    logic [30:0] r_seconds;
    logic [29:0] w_minutes_x60;
    logic [30:0] w_new_seconds;
    logic [30:0] w_seconds;

    // output register free or being drained
    assign o_pop = i_rec_valid && (!r_valid || !i_stall);

    // minutes * 60 as minutes * 64 - minutes * 4, then the epoch shift
    always_comb begin
        w_minutes_x60 = {i_rec.date_minutes, 6'd0} - {4'd0, i_rec.date_minutes, 2'd0};
        w_new_seconds = {1'b0, w_minutes_x60} + EPOCH_SHIFT_SECONDS;
        if (!i_rec.mfg_valid) begin
            w_seconds = 31'd0;
        end else if (i_rec.date_load) begin
            w_seconds = w_new_seconds;
        end else begin
            w_seconds = r_seconds;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload and held conversion
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out         <= i_rec;
            r_out_seconds <= w_seconds;
            if (i_rec.date_load) begin
                r_seconds <= w_new_seconds;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_byte_role    = r_out.role;
    assign o_field_number = r_out.field_number;
    assign o_field_type   = r_out.field_type;
    assign o_field_length = r_out.field_length;
    assign o_data_byte    = r_out.data_byte;
    assign o_header_value = r_out.header_value;
    assign o_mfg_seconds  = r_out_seconds;
    assign o_status       = r_out.status;
    assign o_area_done    = r_out.area_done;

endmodule

`default_nettype wire

>>> sv/fru_info_area_parser_top.sv
// Parser for one IPMI FRU chassis, board or product info area, one byte per transfer.
// Each accepted byte gives exactly one result transfer carrying its role, field number,
// type/length decode and status; a board area also reports its manufacturing time in
// seconds from the third date byte on (epoch shift of 26 years of 365 days). Bytes are
// accepted one per clock while the queue has room, the parse state advancing once per
// accepted byte; while the output stalls up to QUEUE_DEPTH + 1 results (queue entries
// plus the output register) can wait before the input stalls. A result goes into the
// queue when its byte transfers and then into the output register, which presents it.
// Configuration (area kind, custom field limit) must be written only between areas;
// the block does not enforce this. Depends on fru_pkg, fru_front, fru_queue and fru_back.
`timescale 1ns / 1ps
`default_nettype none

module fru_info_area_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic          i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_area_byte,
    input  wire logic          i_last_byte,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_byte_role,
    output logic [7:0]         o_field_number,
    output logic [1:0]         o_field_type,
    output logic [5:0]         o_field_length,
    output logic [7:0]         o_data_byte,
    output logic [7:0]         o_header_value,
    output logic [30:0]        o_mfg_seconds,
    output logic [1:0]         o_status,
    output logic               o_area_done
);
    import fru_pkg::*;

    logic w_full;
    logic w_take;
    logic w_not_empty;
    logic w_pop;
    t_rec w_front_rec;
    t_rec w_head_rec;

    // input transfer when the queue has room
    assign o_stall = w_full;
    assign w_take  = i_valid && !w_full;

    // parse front
    fru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_area_byte (i_area_byte),
        .i_last_byte (i_last_byte),
        .o_rec       (w_front_rec)
    );

    // record queue
    fru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_take),
        .i_rec       (w_front_rec),
        .i_pop       (w_pop),
        .o_rec       (w_head_rec),
        .o_full      (w_full),
        .o_not_empty (w_not_empty)
    );

    // conversion and output stage
    fru_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_valid    (w_not_empty),
        .i_rec          (w_head_rec),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_role    (o_byte_role),
        .o_field_number (o_field_number),
        .o_field_type   (o_field_type),
        .o_field_length (o_field_length),
        .o_data_byte    (o_data_byte),
        .o_header_value (o_header_value),
        .o_mfg_seconds  (o_mfg_seconds),
        .o_status       (o_status),
        .o_area_done    (o_area_done)
    );

endmodule

`default_nettype wire
